>>> sv/dfd_pkg.sv
// Package: constants, control word format, glyph table and shared types.
`timescale 1ns / 1ps
package dfd_pkg;

	localparam int MAX_DIGITS = 8;
	localparam int VALUE_W    = 32;
	localparam int BCD_DIGITS = 10;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int CNT_W      = $clog2(VALUE_W + 1);
	localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int WID_W      = 4;
	localparam int COORD_W    = 16;
	localparam int GW_W       = 6;
	localparam int FONT_W     = 4;
	localparam int ALIGN_W    = 2;
	localparam int PIC_W      = 8;
	localparam int CHAR_W     = 7;
	localparam int CFG_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int PC_W       = 3;

	localparam logic [FONT_W-1:0]  FONT_MAX   = 4'd10;
	localparam logic [PIC_W-1:0]   NO_PICTURE = 8'hFF;
	localparam logic [CHAR_W-1:0]  ASCII_ZERO = 7'h30;
	localparam logic [ALIGN_W-1:0] ALIGN_LEFT = 2'd0;
	localparam logic [ALIGN_W-1:0] ALIGN_CTR  = 2'd1;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_FONT_SIZE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALIGN_MODE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIELD_DIG  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BG_PICTURE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FORE_COLOR = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR = 3'd5;

	typedef enum logic [2:0] {
		OP_LOAD,
		OP_CONV,
		OP_PREP,
		OP_CLEAR,
		OP_CHAR,
		OP_NOP
	} op_t;

	typedef enum logic [2:0] {
		JC_NEVER,
		JC_ALWAYS,
		JC_CONV_MORE,
		JC_NO_PIC,
		JC_DIG_MORE
	} jcond_t;

	typedef struct packed {
		op_t             op;
		jcond_t          jc;
		logic [PC_W-1:0] tgt;
	} ucode_t;

	// step issued to the datapath; go is low while the step is stalled
	typedef struct packed {
		op_t  op;
		logic go;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic out_free;
		logic conv_more;
		logic no_pic;
		logic dig_more;
	} status_t;

	typedef struct packed {
		logic               kind;
		logic [COORD_W-1:0] sx;
		logic [COORD_W-1:0] sy;
		logic [COORD_W-1:0] ex;
		logic [COORD_W-1:0] ey;
		logic [CHAR_W-1:0]  code;
		logic               last;
	} cmd_t;

	localparam logic [PC_W-1:0] PC_LOAD  = 3'd0;
	localparam logic [PC_W-1:0] PC_CONV  = 3'd1;
	localparam logic [PC_W-1:0] PC_PREP  = 3'd2;
	localparam logic [PC_W-1:0] PC_CLEAR = 3'd3;
	localparam logic [PC_W-1:0] PC_CHAR  = 3'd4;
	localparam logic [PC_W-1:0] PC_DONE  = 3'd5;

	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t uc;
		unique case (pc)
			PC_LOAD:  uc = '{op: OP_LOAD,  jc: JC_NEVER,     tgt: PC_LOAD};
			PC_CONV:  uc = '{op: OP_CONV,  jc: JC_CONV_MORE, tgt: PC_CONV};
			PC_PREP:  uc = '{op: OP_PREP,  jc: JC_NO_PIC,    tgt: PC_CHAR};
			PC_CLEAR: uc = '{op: OP_CLEAR, jc: JC_NEVER,     tgt: PC_LOAD};
			PC_CHAR:  uc = '{op: OP_CHAR,  jc: JC_DIG_MORE,  tgt: PC_CHAR};
			PC_DONE:  uc = '{op: OP_NOP,   jc: JC_ALWAYS,    tgt: PC_LOAD};
			default:  uc = '{op: OP_NOP,   jc: JC_ALWAYS,    tgt: PC_LOAD};
		endcase
		return uc;
	endfunction

	function automatic logic [GW_W-1:0] glyph_width(input logic [FONT_W-1:0] fs);
		logic [GW_W-1:0] w;
		case (fs)
			4'd0:    w = 6'd6;
			4'd1:    w = 6'd8;
			4'd2:    w = 6'd12;
			4'd3:    w = 6'd16;
			4'd4:    w = 6'd20;
			4'd5:    w = 6'd24;
			4'd6:    w = 6'd28;
			4'd7:    w = 6'd32;
			4'd8:    w = 6'd40;
			4'd9:    w = 6'd48;
			default: w = 6'd56;
		endcase
		return w;
	endfunction

endpackage

>>> sv/dfd_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
`timescale 1ns / 1ps
module dfd_seq
	import dfd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  status_t st,
	output ctrl_t   ctrl
);

	logic [PC_W-1:0] pc_q;
	ucode_t          uc;
	logic            stall;
	logic            taken;

	always_comb begin
		uc = ucode_rom(pc_q);
		unique case (uc.op) inside
			OP_LOAD:           stall = !st.in_valid;
			OP_CLEAR, OP_CHAR: stall = !st.out_free;
			default:           stall = 1'b0;
		endcase
		unique case (uc.jc)
			JC_NEVER:     taken = 1'b0;
			JC_ALWAYS:    taken = 1'b1;
			JC_CONV_MORE: taken = st.conv_more;
			JC_NO_PIC:    taken = st.no_pic;
			JC_DIG_MORE:  taken = st.dig_more;
			default:      taken = 1'b0;
		endcase
		ctrl.op = uc.op;
		ctrl.go = !stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_LOAD;
		end else if (!stall) begin
			pc_q <= taken ? uc.tgt : pc_q + 1'b1;
		end
	end

`ifndef ASSERT_OFF
	a_load_to_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_LOAD && ctrl.go) |=> (ctrl.op == OP_CONV))
		else $error("accepted transaction not followed by conversion");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.go && (ctrl.op == OP_CLEAR || ctrl.op == OP_CHAR)) |-> st.out_free)
		else $error("command issued while output register is full");
`endif

endmodule

>>> sv/dfd_bcd.sv
// Shift-and-add-3 binary to BCD converter, one input bit per cycle.
`timescale 1ns / 1ps
module dfd_bcd
	import dfd_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  ctrl_t                         ctrl,
	input  logic [VALUE_W-1:0]            value,
	output logic [BCD_DIGITS-1:0][3:0]    digits,
	output logic                          conv_more
);

	logic [VALUE_W-1:0] bin_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [BCD_W-1:0]   adj;

	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
			                                          : bcd_q[i*4 +: 4];
		end
	end

	assign digits    = bcd_q;
	assign conv_more = (cnt_q != CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.go && ctrl.op == OP_LOAD) begin
			cnt_q <= CNT_W'(VALUE_W);
		end else if (ctrl.go && ctrl.op == OP_CONV) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.go && ctrl.op == OP_LOAD) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (ctrl.go && ctrl.op == OP_CONV) begin
			bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], bin_q[VALUE_W-1]};
		end
	end

`ifndef ASSERT_OFF
	a_conv_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_CONV) |-> (cnt_q != '0))
		else $error("conversion step with no bits left");
`endif

endmodule

>>> sv/dfd_dp.sv
// Command datapath: field geometry, digit walk and the output register.
`timescale 1ns / 1ps
module dfd_dp
	import dfd_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  ctrl_t                      ctrl,
	input  logic [COORD_W-1:0]         pos_x,
	input  logic [COORD_W-1:0]         pos_y,
	input  logic [FONT_W-1:0]          font_size,
	input  logic [ALIGN_W-1:0]         align_mode,
	input  logic [WID_W-1:0]           field_digits,
	input  logic [PIC_W-1:0]           background_picture,
	input  logic [BCD_DIGITS-1:0][3:0] digits,
	input  logic                       out_ready,
	output logic                       no_pic,
	output logic                       dig_more,
	output logic                       out_free,
	output logic                       out_valid,
	output cmd_t                       out_cmd
);

	logic [COORD_W-1:0] px_q, py_q, xs_q, ex_q;
	logic [GW_W-1:0]    gw_q;
	logic [WID_W-1:0]   wid_q;
	logic [IDX_W-1:0]   idx_q;
	logic               out_valid_q;
	cmd_t               out_q;

	logic [FONT_W-1:0]  fs_sat;
	logic [WID_W-1:0]   wid_sat;
	logic [WID_W-1:0]   sig;
	logic [WID_W-1:0]   n;
	logic [WID_W-1:0]   gap;
	logic [GW_W-1:0]    step;
	logic [COORD_W-1:0] xs_base;
	logic [COORD_W-1:0] ey;
	logic [MAX_DIGITS-1:0][3:0] shown;

	always_comb begin
		fs_sat = (font_size > FONT_MAX) ? FONT_MAX : font_size;
		if (field_digits == '0)
			wid_sat = WID_W'(1);
		else if (field_digits > WID_W'(MAX_DIGITS))
			wid_sat = WID_W'(MAX_DIGITS);
		else
			wid_sat = field_digits;

		// significant digits, at least one so zero shows
		sig = WID_W'(1);
		for (int k = 1; k < BCD_DIGITS; k++) begin
			if (digits[k] != 4'd0)
				sig = WID_W'(k + 1);
		end
		n   = (sig > wid_q) ? wid_q : sig;
		gap = wid_q - n;

		case (align_mode)
			ALIGN_LEFT: step = '0;
			ALIGN_CTR:  step = gw_q >> 1;
			default:    step = gw_q;
		endcase
		xs_base = px_q + COORD_W'(gap * step);
		ey      = py_q + (COORD_W'(gw_q) << 1);
		shown   = digits[MAX_DIGITS-1:0];
	end

	assign no_pic    = (background_picture == NO_PICTURE);
	assign dig_more  = (idx_q != '0);
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_cmd   = out_q;

	always_ff @(posedge clk) begin
		if (ctrl.go) begin
			unique case (ctrl.op)
				OP_LOAD: begin
					px_q  <= pos_x;
					py_q  <= pos_y;
					gw_q  <= glyph_width(fs_sat);
					wid_q <= wid_sat;
				end
				OP_PREP: begin
					idx_q <= IDX_W'(n - 1'b1);
					xs_q  <= xs_base;
					ex_q  <= px_q + COORD_W'(wid_q * gw_q);
				end
				OP_CLEAR: begin
					out_q <= '{kind: 1'b0, sx: px_q, sy: py_q, ex: ex_q, ey: ey,
					           code: '0, last: 1'b0};
				end
				OP_CHAR: begin
					out_q <= '{kind: 1'b1, sx: xs_q, sy: py_q, ex: '0, ey: '0,
					           code: ASCII_ZERO + CHAR_W'(shown[idx_q]),
					           last: (idx_q == '0)};
					xs_q  <= xs_q + COORD_W'(gw_q);
					idx_q <= idx_q - 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.go && (ctrl.op == OP_CLEAR || ctrl.op == OP_CHAR)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef ASSERT_OFF
	a_last_is_char: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.last) |-> out_q.kind)
		else $error("clear command flagged as last");
	a_idx_in_field: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_CHAR) |-> (WID_W'(idx_q) < wid_q))
		else $error("digit index beyond field width");
`endif

endmodule

>>> sv/decimal_field_display_commands_top.sv
// Top level: config registers, sequencer, BCD converter and command datapath.
//
//  channel | dir | handshake        | payload
//  s_*     | in  | tvalid/tready    | tdata: value, pos_x, pos_y
//  m_*     | out | tvalid/tready    | tdata: start_x..char_code, tuser: cmd_kind, tlast: last
//  cfg_*   | in  | cfg_we           | cfg_idx, cfg_wdata
//
// Each value runs through a load, one conversion step per bit of the 32-bit value (the converter
// shifts in one input bit per cycle), a setup step, an optional clear command, one
// character command per digit shown and a return step. A full output register
// stalls the program at the command step. arst_n clears the program counter, the
// output valid and the config registers to their reset values.
`timescale 1ns / 1ps
module decimal_field_display_commands_top
	import dfd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [63:0]          s_tdata,   // value[31:0], pos_x[47:32], pos_y[63:48]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [71:0]          m_tdata,   // start_x, start_y, end_x, end_y, char_code, pad
	output logic                 m_tuser,   // cmd_kind
	output logic                 m_tlast,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	logic [FONT_W-1:0]  font_q;
	logic [ALIGN_W-1:0] align_q;
	logic [WID_W-1:0]   digits_q;
	logic [PIC_W-1:0]   pic_q;

	ctrl_t                      ctrl;
	status_t                    st;
	logic [BCD_DIGITS-1:0][3:0] bcd_digits;
	logic                       conv_more;
	logic                       no_pic;
	logic                       dig_more;
	logic                       out_free;
	cmd_t                       cmd;

	// writes to the color registers are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_q   <= '0;
			align_q  <= '0;
			digits_q <= WID_W'(MAX_DIGITS);
			pic_q    <= NO_PICTURE;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_FONT_SIZE:  font_q   <= cfg_wdata[FONT_W-1:0];
				REG_ALIGN_MODE: align_q  <= cfg_wdata[ALIGN_W-1:0];
				REG_FIELD_DIG:  digits_q <= cfg_wdata[WID_W-1:0];
				REG_BG_PICTURE: pic_q    <= cfg_wdata[PIC_W-1:0];
				default: ;
			endcase
		end
	end

	assign st = '{in_valid: s_tvalid, out_free: out_free, conv_more: conv_more,
	              no_pic: no_pic, dig_more: dig_more};

	assign s_tready = (ctrl.op == OP_LOAD);

	dfd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.ctrl   (ctrl)
	);

	dfd_bcd u_bcd (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.value     (s_tdata[31:0]),
		.digits    (bcd_digits),
		.conv_more (conv_more)
	);

	dfd_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.ctrl               (ctrl),
		.pos_x              (s_tdata[47:32]),
		.pos_y              (s_tdata[63:48]),
		.font_size          (font_q),
		.align_mode         (align_q),
		.field_digits       (digits_q),
		.background_picture (pic_q),
		.digits             (bcd_digits),
		.out_ready          (m_tready),
		.no_pic             (no_pic),
		.dig_more           (dig_more),
		.out_free           (out_free),
		.out_valid          (m_tvalid),
		.out_cmd            (cmd)
	);

	assign m_tdata = {1'b0, cmd.code, cmd.ey, cmd.ex, cmd.sy, cmd.sx};
	assign m_tuser = cmd.kind;
	assign m_tlast = cmd.last;

endmodule

>>> tb/sv/tb_decimal_field_display_commands_top.sv
// Testbench for decimal_field_display_commands_top: directed table plus random values and settings.
`timescale 1ns / 1ps
module tb_decimal_field_display_commands_top;
	import dfd_pkg::*;

	localparam logic KIND_CLEAR = 1'b0;
	localparam logic KIND_CHAR  = 1'b1;
	localparam logic [ALIGN_W-1:0] ALIGN_RIGHT     = 2'd2;
	localparam logic [ALIGN_W-1:0] ALIGN_ALT_RIGHT = 2'd3;
	localparam int QUIET_LIMIT = 2000;
	localparam int NDIR        = 23;
	localparam int NPHASE      = 6;
	localparam int PHASE_ITEMS = 15;

	typedef struct packed {
		logic [FONT_W-1:0]  font;
		logic [ALIGN_W-1:0] align;
		logic [WID_W-1:0]   digits;
		logic [PIC_W-1:0]   pic;
		logic [7:0]         fore;
		logic [7:0]         back;
	} settings_t;

	typedef struct {
		settings_t   cfg;
		logic [31:0] value;
		logic [15:0] px;
		logic [15:0] py;
		int          n_want;
		cmd_t        want [2];
	} row_t;

	localparam settings_t CFG_RESET = '{4'd0, ALIGN_LEFT, 4'd8, NO_PICTURE, 8'd0, 8'd0};
	localparam settings_t CFG_A = '{4'd10, ALIGN_LEFT, 4'd1, 8'd0, 8'hFF, 8'hFF};
	localparam settings_t CFG_B = '{4'd15, ALIGN_CTR, 4'd0, 8'hAA, 8'h55, 8'hAA};
	localparam settings_t CFG_C = '{4'd11, ALIGN_RIGHT, 4'd15, 8'd254, 8'd0, 8'd0};
	localparam settings_t CFG_D = '{4'd3, ALIGN_ALT_RIGHT, 4'd9, NO_PICTURE, 8'h0F, 8'hF0};
	localparam settings_t CFG_E = '{4'd5, ALIGN_CTR, 4'd8, 8'd1, 8'd1, 8'd2};
	localparam settings_t CFG_F = '{4'd0, ALIGN_CTR, 4'd7, 8'd128, 8'd3, 8'd4};
	localparam settings_t CFG_G = '{4'd9, ALIGN_RIGHT, 4'd8, 8'd15, 8'd0, 8'd255};
	localparam settings_t CFG_H = '{4'd7, ALIGN_CTR, 4'd4, NO_PICTURE, 8'd9, 8'd9};
	localparam settings_t CFG_I = '{4'd1, ALIGN_LEFT, 4'd10, 8'd0, 8'd17, 8'd34};
	localparam settings_t CFG_J = '{4'd8, ALIGN_RIGHT, 4'd14, 8'd127, 8'd200, 8'd100};
	localparam settings_t CFG_K = '{4'd2, ALIGN_CTR, 4'd12, NO_PICTURE, 8'd5, 8'd6};

	localparam cmd_t NO_CMD = '0;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [63:0]          s_tdata   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [71:0]          m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx   = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	decimal_field_display_commands_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	settings_t cur = CFG_RESET;
	cmd_t      due_cmds [$];
	int        errors = 0;
	bit        calm = 1'b0;
	int        typed_n = 0;
	cmd_t      typed_cmds [2];
	int        quiet = 0;
	int        stall_left = 0;

	row_t dir_rows [NDIR] = '{
		'{CFG_RESET, 32'd0, 16'd0, 16'd0, 1,
			'{'{KIND_CHAR, 16'd0, 16'd0, 16'd0, 16'd0, ASCII_ZERO, 1'b1}, NO_CMD}},
		'{CFG_RESET, 32'd9, 16'hFFFF, 16'hFFFF, 1,
			'{'{KIND_CHAR, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, ASCII_ZERO + 7'd9, 1'b1}, NO_CMD}},
		'{CFG_RESET, 32'hFFFF_FFFF, 16'd0, 16'd0, 0, '{NO_CMD, NO_CMD}},
		'{CFG_RESET, 32'd12345678, 16'd100, 16'd50, 0, '{NO_CMD, NO_CMD}},
		'{CFG_RESET, 32'd10, 16'd0, 16'hFFFF, 0, '{NO_CMD, NO_CMD}},
		'{CFG_A, 32'd5, 16'd10, 16'd20, 2,
			'{'{KIND_CLEAR, 16'd10, 16'd20, 16'd66, 16'd132, 7'd0, 1'b0},
			  '{KIND_CHAR, 16'd10, 16'd20, 16'd0, 16'd0, ASCII_ZERO + 7'd5, 1'b1}}},
		'{CFG_A, 32'd123, 16'd65500, 16'd65500, 0, '{NO_CMD, NO_CMD}},
		// font code above ten and zero field width, both saturated
		'{CFG_B, 32'd7, 16'd0, 16'd0, 2,
			'{'{KIND_CLEAR, 16'd0, 16'd0, 16'd56, 16'd112, 7'd0, 1'b0},
			  '{KIND_CHAR, 16'd0, 16'd0, 16'd0, 16'd0, ASCII_ZERO + 7'd7, 1'b1}}},
		'{CFG_B, 32'hFFFF_FFFF, 16'd1, 16'd1, 0, '{NO_CMD, NO_CMD}},
		'{CFG_C, 32'd42, 16'd65000, 16'd65530, 0, '{NO_CMD, NO_CMD}},
		'{CFG_C, 32'd0, 16'd0, 16'd0, 0, '{NO_CMD, NO_CMD}},
		'{CFG_D, 32'd1000, 16'd0, 16'd0, 0, '{NO_CMD, NO_CMD}},
		'{CFG_D, 32'd99999999, 16'd5, 16'd5, 0, '{NO_CMD, NO_CMD}},
		'{CFG_E, 32'd1, 16'd300, 16'd300, 0, '{NO_CMD, NO_CMD}},
		'{CFG_E, 32'd12, 16'd300, 16'd300, 0, '{NO_CMD, NO_CMD}},
		'{CFG_F, 32'd123, 16'd0, 16'd0, 0, '{NO_CMD, NO_CMD}},
		'{CFG_G, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 0, '{NO_CMD, NO_CMD}},
		'{CFG_G, 32'd100000000, 16'd0, 16'd0, 0, '{NO_CMD, NO_CMD}},
		'{CFG_H, 32'd100000, 16'd40, 16'd40, 0, '{NO_CMD, NO_CMD}},
		'{CFG_H, 32'd5, 16'd40, 16'd40, 0, '{NO_CMD, NO_CMD}},
		'{CFG_I, 32'd1234567890, 16'd0, 16'd0, 0, '{NO_CMD, NO_CMD}},
		'{CFG_J, 32'd9999, 16'hFFFF, 16'd0, 0, '{NO_CMD, NO_CMD}},
		'{CFG_K, 32'd55, 16'd0, 16'd0, 0, '{NO_CMD, NO_CMD}}
	};

	initial begin
		forever #2 clk = ~clk;
	end

	// queue the commands one value produces under the current settings
	function automatic void plan_commands(logic [31:0] value, logic [15:0] px, logic [15:0] py);
		int unsigned glyph_px [11] = '{6, 8, 12, 16, 20, 24, 28, 32, 40, 48, 56};
		int unsigned fs, gw, wid, n;
		logic [31:0] t;
		logic [15:0] xs;
		logic [3:0]  dig [10];
		cmd_t c;
		fs  = (cur.font > FONT_MAX) ? FONT_MAX : cur.font;
		gw  = glyph_px[fs];
		wid = cur.digits;
		if (wid == 0) wid = 1;
		if (wid > MAX_DIGITS) wid = MAX_DIGITS;
		t = value;
		for (int k = 0; k < 10; k++) begin
			dig[k] = 4'(t % 10);
			t = t / 10;
		end
		n = 0;
		t = value;
		do begin
			n++;
			t = t / 10;
		end while (t > 0);
		if (n > wid) n = wid;
		if (cur.pic != NO_PICTURE) begin
			c = '{KIND_CLEAR, px, py, 16'(px + wid * gw), 16'(py + 2 * gw), 7'd0, 1'b0};
			due_cmds.push_back(c);
		end
		if (cur.align == ALIGN_LEFT)
			xs = px;
		else if (cur.align == ALIGN_CTR)
			xs = 16'((wid - n) * (gw / 2) + px);
		else
			xs = 16'((wid - n) * gw + px);
		for (int k = int'(n) - 1; k >= 0; k--) begin
			c = '{KIND_CHAR, xs, py, 16'd0, 16'd0, ASCII_ZERO + 7'(dig[k]), 1'(k == 0)};
			due_cmds.push_back(c);
			xs = 16'(xs + gw);
		end
	endfunction

	task automatic cmp_field(string name, int unsigned want, int unsigned got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// inputs sampled at the rising edge; outputs settle only after it
	always @(posedge clk) begin : watch
		cmd_t got;
		cmd_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				if (typed_n > 0) begin
					for (int k = 0; k < typed_n; k++) due_cmds.push_back(typed_cmds[k]);
				end else begin
					plan_commands(s_tdata[31:0], s_tdata[47:32], s_tdata[63:48]);
				end
			end
			if (m_tvalid && m_tready) begin
				got = '{m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[47:32],
					m_tdata[63:48], m_tdata[70:64], m_tlast};
				if (due_cmds.size() == 0) begin
					$display("%0t: unexpected transaction, expected none, got %p", $time, got);
					errors++;
				end else begin
					want = due_cmds.pop_front();
					cmp_field("cmd_kind", want.kind, got.kind);
					cmp_field("start_x", want.sx, got.sx);
					cmp_field("start_y", want.sy, got.sy);
					cmp_field("end_x", want.ex, got.ex);
					cmp_field("end_y", want.ey, got.ey);
					cmp_field("char_code", want.code, got.code);
					cmp_field("last", want.last, got.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("FAIL decimal_field_display_commands_top");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	// downstream backpressure in bursts
	always @(negedge clk) begin : sink
		logic rdy;
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			rdy = 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 19) - 1;
			rdy = 1'b0;
		end else begin
			rdy = 1'b1;
		end
		m_tready <= rdy;
	end

	// entered and left at a falling edge; valid stays high for the caller to change
	task automatic send_item(logic [31:0] value, logic [15:0] px, logic [15:0] py);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {py, px, value};
		do @(posedge clk); while (!(s_tvalid && s_tready));
		@(negedge clk);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (due_cmds.size() > 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic poke_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_settings(settings_t c);
		poke_reg(REG_FONT_SIZE, CFG_W'(c.font));
		poke_reg(REG_ALIGN_MODE, CFG_W'(c.align));
		poke_reg(REG_FIELD_DIG, CFG_W'(c.digits));
		poke_reg(REG_BG_PICTURE, c.pic);
		poke_reg(REG_FORE_COLOR, c.fore);
		poke_reg(REG_BACK_COLOR, c.back);
		cur = c;
	endtask

	initial begin : stim
		settings_t c;
		logic [31:0] v;
		logic [15:0] x;
		logic [15:0] y;
		longint unsigned top;
		int k;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int r = 0; r < NDIR; r++) begin
			if (dir_rows[r].cfg != cur) begin
				settle();
				load_settings(dir_rows[r].cfg);
			end
			typed_n = dir_rows[r].n_want;
			typed_cmds = dir_rows[r].want;
			send_item(dir_rows[r].value, dir_rows[r].px, dir_rows[r].py);
		end
		typed_n = 0;

		for (int ph = 0; ph < NPHASE; ph++) begin
			if (ph == NPHASE - 1) calm = 1'b1;
			c.font   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(11, 15))
			                                        : 4'($urandom_range(0, 10));
			c.align  = 2'($urandom_range(0, 3));
			if ($urandom_range(0, 4) == 0)
				c.digits = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
			else
				c.digits = 4'($urandom_range(1, 8));
			c.pic    = ($urandom_range(0, 2) == 0) ? NO_PICTURE : 8'($urandom_range(0, 255));
			c.fore   = 8'($urandom_range(0, 255));
			c.back   = 8'($urandom_range(0, 255));
			settle();
			load_settings(c);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				k = $urandom_range(1, 10);
				top = 1;
				repeat (k) top = top * 10;
				case ($urandom_range(0, 4))
					0: v = $urandom;
					1: v = (top > 64'hFFFF_FFFF) ? $urandom : $urandom_range(0, 32'(top - 1));
					// digit-count boundaries: a power of ten and one below it
					2: v = 32'(top / 10) - $urandom_range(0, 1);
					3: v = 32'hFFFF_FFFF - $urandom_range(0, 3);
					default: v = $urandom_range(0, 9);
				endcase
				case ($urandom_range(0, 2))
					0: begin x = 16'($urandom); y = 16'($urandom); end
					1: begin
						x = 16'hFFFF - 16'($urandom_range(0, 600));
						y = 16'hFFFF - 16'($urandom_range(0, 300));
					end
					default: begin
						x = 16'($urandom_range(0, 200));
						y = 16'($urandom_range(0, 200));
					end
				endcase
				send_item(v, x, y);
			end
		end

		settle();
		repeat (48) @(negedge clk);
		if (errors == 0)
			$display("PASS decimal_field_display_commands_top");
		else
			$display("FAIL decimal_field_display_commands_top");
		$finish;
	end

endmodule
